/* rtl/nearest_stop_search_defines.svh */
// assertion macros for the checker file
`ifndef NEAREST_STOP_SEARCH_DEFINES_SVH
`define NEAREST_STOP_SEARCH_DEFINES_SVH

// same-cycle implication, disabled in reset
`define NSS_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("nearest_stop_search: same-cycle check failed");

// next-cycle implication, disabled in reset
`define NSS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("nearest_stop_search: next-cycle check failed");

`endif

/* rtl/nss_pkg.sv */
package nss_pkg;

  localparam int MAX_STOPS_DEF = 64;

  // item field widths
  localparam int SLOT_W  = 6;
  localparam int LINE_W  = 2;
  localparam int LAT_W   = 28;
  localparam int LON_W   = 29;
  localparam int LED_W   = 8;
  localparam int COUNT_W = 7;
  localparam int SCALE_W = 16;
  localparam int LEVEL_W = 12;
  localparam int DIST_W  = 58;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int TDATA_W = 80;

  // datapath widths
  localparam int ALAT_W   = LAT_W;            // |dlat| below 2^28
  localparam int ALON_W   = LON_W;            // |dlon| below 2^29
  localparam int SLON_W   = 30;               // scaled |dlon|, scale below 2
  localparam int MUL_W    = 30;
  localparam int PROD_W   = 2 * MUL_W;
  localparam int SCALED_W = ALON_W + SCALE_W;
  localparam int LATSQ_W  = 2 * ALAT_W;
  localparam int SUM_W    = PROD_W + 1;
  localparam int ROUND_SHIFT = 15;
  localparam logic [SCALED_W:0] ROUND_HALF = (SCALED_W + 1)'(1 << (ROUND_SHIFT - 1));

  // register indexes and reset values
  localparam logic [CFG_INDEX_W-1:0] REG_STOP_COUNT   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LON_SCALE    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_BRIGHT_LEVEL = 2'd2;
  localparam logic [COUNT_W-1:0] STOP_COUNT_RST   = 7'd0;
  localparam logic [SCALE_W-1:0] LON_SCALE_RST    = 16'd23203;
  localparam logic [LEVEL_W-1:0] BRIGHT_LEVEL_RST = 12'd1000;

  typedef enum logic {
    FUNC_LOAD  = 1'b0,
    FUNC_QUERY = 1'b1
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_DIFF,
    ST_MUL_SCALE,
    ST_MUL_LAT,
    ST_MUL_LON,
    ST_ACC,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [LINE_W-1:0] line_id;
    logic [LAT_W-1:0]  lat;
    logic [LON_W-1:0]  lon;
    logic [LED_W-1:0]  led;
  } stop_entry_t;

  typedef struct packed {
    func_t             func;
    logic [SLOT_W-1:0] slot;
    logic [LINE_W-1:0] line_id;
    logic [LAT_W-1:0]  lat_micro;
    logic [LON_W-1:0]  lon_micro;
    logic [LED_W-1:0]  led_number;
    logic              outbound;
  } item_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] slot;
    stop_entry_t       entry;
  } tbl_wr_t;

  typedef struct packed {
    logic [MUL_W-1:0] a;
    logic [MUL_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic [LED_W-1:0]   nearest_led;
    logic [LEVEL_W-1:0] level;
    logic               found;
    logic [DIST_W-1:0]  distance_sq;
  } result_t;

endpackage

/* rtl/nss_table.sv */
module nss_table import nss_pkg::*; #(
  parameter int MAX_STOPS = MAX_STOPS_DEF,
  localparam int ADDR_W = (MAX_STOPS > 1) ? $clog2(MAX_STOPS) : 1
) (
  input  logic              clk,
  input  tbl_wr_t           wr,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output stop_entry_t       rd_data
);

  stop_entry_t mem [MAX_STOPS];

  // loads past the end of the table are dropped
  always_ff @(posedge clk) begin
    if (wr.en && (int'(wr.slot) < MAX_STOPS)) begin
      mem[ADDR_W'(wr.slot)] <= wr.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/nss_mul.sv */
module nss_mul import nss_pkg::*; (
  input  logic              clk,
  input  mul_req_t          req,
  output logic [PROD_W-1:0] prod
);

  always_ff @(posedge clk) begin
    prod <= PROD_W'(req.a) * PROD_W'(req.b);
  end

endmodule

/* rtl/nss_seq.sv */
module nss_seq import nss_pkg::*; #(
  parameter int MAX_STOPS = MAX_STOPS_DEF,
  localparam int ADDR_W = (MAX_STOPS > 1) ? $clog2(MAX_STOPS) : 1,
  localparam int CNT_W  = $clog2(MAX_STOPS + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  item_t              in_item,
  input  logic [COUNT_W-1:0] stop_count,
  input  logic [SCALE_W-1:0] lon_scale,
  input  logic [LEVEL_W-1:0] bright_level,
  output tbl_wr_t            tbl_wr,
  output logic               rd_en,
  output logic [ADDR_W-1:0]  rd_addr,
  input  stop_entry_t        rd_data,
  output mul_req_t           mul_req,
  input  logic [PROD_W-1:0]  prod,
  output logic               res_valid,
  input  logic               res_ready,
  output result_t            res
);

  state_t state, state_next;

  logic [CNT_W-1:0]   idx;
  logic [CNT_W-1:0]   limit;
  logic [LINE_W-1:0]  q_line;
  logic [LAT_W-1:0]   q_lat;
  logic [LON_W-1:0]   q_lon;
  logic               q_outbound;
  logic [ALAT_W-1:0]  alat;
  logic [ALON_W-1:0]  alon;
  logic [SLON_W-1:0]  slon;
  logic [LATSQ_W-1:0] lat_sq;
  logic [SUM_W-1:0]   best;
  logic [LED_W-1:0]   best_led;
  logic               found;

  logic [LAT_W:0]     dlat;
  logic [LON_W:0]     dlon;
  logic [LAT_W:0]     dlat_abs;
  logic [LON_W:0]     dlon_abs;
  logic [SCALED_W:0]  rsum;
  logic [SUM_W-1:0]   cand_sum;
  logic               better;

  // search length clipped to the table
  always_comb begin
    if (int'(stop_count) > MAX_STOPS) begin
      limit = CNT_W'(MAX_STOPS);
    end else begin
      limit = CNT_W'(stop_count);
    end
  end

  // difference magnitudes, rounding of the scaled longitude, distance sum
  always_comb begin
    dlat = {q_lat[LAT_W-1], q_lat} - {rd_data.lat[LAT_W-1], rd_data.lat};
    dlon = {q_lon[LON_W-1], q_lon} - {rd_data.lon[LON_W-1], rd_data.lon};
    dlat_abs = dlat[LAT_W] ? (~dlat + 1'b1) : dlat;
    dlon_abs = dlon[LON_W] ? (~dlon + 1'b1) : dlon;
    rsum = {1'b0, prod[SCALED_W-1:0]} + ROUND_HALF;
    cand_sum = SUM_W'(lat_sq) + SUM_W'(prod);
    better = !found || (cand_sum < best);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = idx[ADDR_W-1:0];
    mul_req    = '0;
    res_valid  = 1'b0;
    tbl_wr.en    = 1'b0;
    tbl_wr.slot  = in_item.slot;
    tbl_wr.entry = '{line_id: in_item.line_id, lat: in_item.lat_micro,
                     lon: in_item.lon_micro, led: in_item.led_number};
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_item.func == FUNC_QUERY) begin
            state_next = ST_READ;
          end else begin
            tbl_wr.en = 1'b1;
          end
        end
      end
      ST_READ: begin
        if (idx == limit) begin
          state_next = ST_DONE;
        end else begin
          rd_en      = 1'b1;
          state_next = ST_DIFF;
        end
      end
      ST_DIFF: begin
        if (rd_data.line_id != q_line) begin
          state_next = ST_READ;
        end else begin
          state_next = ST_MUL_SCALE;
        end
      end
      ST_MUL_SCALE: begin
        mul_req.a  = MUL_W'(alon);
        mul_req.b  = MUL_W'(lon_scale);
        state_next = ST_MUL_LAT;
      end
      ST_MUL_LAT: begin
        mul_req.a  = MUL_W'(alat);
        mul_req.b  = MUL_W'(alat);
        state_next = ST_MUL_LON;
      end
      ST_MUL_LON: begin
        mul_req.a  = MUL_W'(slon);
        mul_req.b  = MUL_W'(slon);
        state_next = ST_ACC;
      end
      ST_ACC: begin
        state_next = ST_READ;
      end
      ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx   <= '0;
      found <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid && (in_item.func == FUNC_QUERY)) begin
            idx   <= '0;
            found <= 1'b0;
          end
        end
        ST_DIFF: begin
          if (rd_data.line_id != q_line) begin
            idx <= idx + 1'b1;
          end
        end
        ST_ACC: begin
          idx <= idx + 1'b1;
          if (better) begin
            found <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_IDLE) && in_valid) begin
      q_line     <= in_item.line_id;
      q_lat      <= in_item.lat_micro;
      q_lon      <= in_item.lon_micro;
      q_outbound <= in_item.outbound;
    end
    if (state == ST_DIFF) begin
      alat <= dlat_abs[ALAT_W-1:0];
      alon <= dlon_abs[ALON_W-1:0];
    end
    if (state == ST_MUL_LAT) begin
      slon <= rsum[ROUND_SHIFT+SLON_W-1:ROUND_SHIFT];
    end
    if (state == ST_MUL_LON) begin
      lat_sq <= prod[LATSQ_W-1:0];
    end
    if ((state == ST_ACC) && better) begin
      best     <= cand_sum;
      best_led <= rd_data.led;
    end
  end

  // result, saturating the distance
  always_comb begin
    res = '0;
    if (found) begin
      res.nearest_led = best_led;
      res.level       = q_outbound ? '0 : bright_level;
      res.found       = 1'b1;
      if (|best[SUM_W-1:DIST_W]) begin
        res.distance_sq = '1;
      end else begin
        res.distance_sq = best[DIST_W-1:0];
      end
    end
  end

endmodule

/* rtl/nearest_stop_search.sv */
// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  load or query request, func in s_tuser
// m_*       out  m_tvalid/m_tready  one result per query request
// cfg_*     in   cfg_valid/cfg_ready register index and write data
//
// a load request writes the table; s_tready stays high after it
// a query reads each searched slot and checks its line; a stop on the queried
// line is multiplied and accumulated before the result sits in the output register;
// the single shared 30x30 multiplier runs three times per matching stop
// and the table gives one registered read per slot
// rst is synchronous, active high; the stop table is not cleared
// a result waiting on m_tready does not block the next request
module nearest_stop_search import nss_pkg::*; #(
  parameter int MAX_STOPS = MAX_STOPS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // slot[5:0], line_id[7:6], lat_micro[35:8], lon_micro[64:36],
  // led_number[72:65], outbound[73], zero fill above
  input  logic [TDATA_W-1:0]     s_tdata,
  // func[0]
  input  logic [0:0]             s_tuser,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // nearest_led[7:0], level[19:8], found[20], distance_sq[78:21], zero fill above
  output logic [TDATA_W-1:0]     m_tdata,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int ADDR_W = (MAX_STOPS > 1) ? $clog2(MAX_STOPS) : 1;

  logic [COUNT_W-1:0] stop_count;
  logic [SCALE_W-1:0] lon_scale;
  logic [LEVEL_W-1:0] bright_level;

  item_t             in_item;
  tbl_wr_t           tbl_wr;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  stop_entry_t       rd_data;
  mul_req_t          mul_req;
  logic [PROD_W-1:0] prod;
  logic              res_valid;
  logic              res_ready;
  result_t           res;

  // configuration registers, always ready; unknown index is ignored
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      stop_count   <= STOP_COUNT_RST;
      lon_scale    <= LON_SCALE_RST;
      bright_level <= BRIGHT_LEVEL_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_STOP_COUNT:   stop_count   <= cfg_data[COUNT_W-1:0];
        REG_LON_SCALE:    lon_scale    <= cfg_data[SCALE_W-1:0];
        REG_BRIGHT_LEVEL: bright_level <= cfg_data[LEVEL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // unpack the request
  assign in_item.func       = func_t'(s_tuser[0]);
  assign in_item.slot       = s_tdata[5:0];
  assign in_item.line_id    = s_tdata[7:6];
  assign in_item.lat_micro  = s_tdata[35:8];
  assign in_item.lon_micro  = s_tdata[64:36];
  assign in_item.led_number = s_tdata[72:65];
  assign in_item.outbound   = s_tdata[73];

  nss_table #(
    .MAX_STOPS (MAX_STOPS)
  ) u_table (
    .clk     (clk),
    .wr      (tbl_wr),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  nss_mul u_mul (
    .clk  (clk),
    .req  (mul_req),
    .prod (prod)
  );

  nss_seq #(
    .MAX_STOPS (MAX_STOPS)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .in_item      (in_item),
    .stop_count   (stop_count),
    .lon_scale    (lon_scale),
    .bright_level (bright_level),
    .tbl_wr       (tbl_wr),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data),
    .mul_req      (mul_req),
    .prod         (prod),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res)
  );

  // output register, loads when empty or being drained
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      m_tdata <= {1'b0, res.distance_sq, res.found, res.level, res.nearest_led};
    end
  end

endmodule

/* rtl/nss_checker.sv */
`include "nearest_stop_search_defines.svh"

module nss_checker import nss_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               s_tvalid,
  input logic               s_tready,
  input logic [0:0]         s_tuser,
  input logic               m_tvalid,
  input logic               m_tready,
  input logic [TDATA_W-1:0] m_tdata
);

  // a stalled result holds
  `NSS_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

  // a miss reports all zeros
  `NSS_ASSERT_SAME(a_miss_zero, clk, rst, m_tvalid && !m_tdata[20], m_tdata == '0)

  // a load finishes in its own cycle
  `NSS_ASSERT_NEXT(a_load_fast, clk, rst, s_tvalid && s_tready && (s_tuser[0] == FUNC_LOAD), s_tready)

  // a query keeps the block busy
  `NSS_ASSERT_NEXT(a_query_busy, clk, rst, s_tvalid && s_tready && (s_tuser[0] == FUNC_QUERY), !s_tready)

endmodule

bind nearest_stop_search nss_checker u_nss_checker (.*);
